[hw/rtl/ddr3spd_pkg.sv]
// Shared types, constants and the CRC byte step for the DDR3 SPD decoder.
// Depends on nothing; the top, front and back files use it by scoped names.
package ddr3spd_pkg;

  localparam int SPD_BYTES   = 128;
  localparam int ADDR_W      = $clog2(SPD_BYTES);
  localparam int SWEEP_W     = $clog2(SPD_BYTES) + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int COPY_BYTES  = 33;
  localparam int COPY_W      = $clog2(COPY_BYTES);
  localparam int DIV_STEPS   = 16;
  localparam int PADDR_W     = 3;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [ADDR_W-1:0] CRC_SHORT_LEN = 7'd117;
  localparam logic [ADDR_W-1:0] CRC_LONG_LEN  = 7'd126;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0f;
  localparam logic [7:0] HIGH_NIBBLE = 8'hf0;

  localparam logic [ADDR_W-1:0] START_ADDR  = 7'd127;
  localparam logic [ADDR_W-1:0] MIRROR_BYTE = 7'd60;
  localparam logic [ADDR_W-1:0] CRC_LO_BYTE = 7'd126;
  localparam logic [ADDR_W-1:0] CRC_HI_BYTE = 7'd127;

  localparam logic [7:0] DDR3_TYPE_RESET = 8'd11;
  // register word index on the configuration port
  localparam logic REG_TYPE_CODE = 1'b0;

  localparam logic [4:0] ATTR_STATUS  = 5'd0;
  localparam logic [4:0] ATTR_ROWBITS = 5'd1;
  localparam logic [4:0] ATTR_COLBITS = 5'd2;
  localparam logic [4:0] ATTR_RANKS   = 5'd3;
  localparam logic [4:0] ATTR_SIZE    = 5'd4;
  localparam logic [4:0] ATTR_FLAGS   = 5'd5;
  localparam logic [4:0] ATTR_CAS     = 5'd6;
  localparam logic [4:0] ATTR_TCK     = 5'd7;
  localparam logic [4:0] ATTR_TAA     = 5'd8;
  localparam logic [4:0] ATTR_TWR     = 5'd9;
  localparam logic [4:0] ATTR_TRCD    = 5'd10;
  localparam logic [4:0] ATTR_TRRD    = 5'd11;
  localparam logic [4:0] ATTR_TRP     = 5'd12;
  localparam logic [4:0] ATTR_TRAS    = 5'd13;
  localparam logic [4:0] ATTR_TRC     = 5'd14;
  localparam logic [4:0] ATTR_TRFC    = 5'd15;
  localparam logic [4:0] ATTR_TWTR    = 5'd16;
  localparam logic [4:0] ATTR_TRTP    = 5'd17;
  localparam logic [4:0] ATTR_TFAW    = 5'd18;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        spd_byte;
  } spd_in_t;

  typedef struct packed {
    logic [4:0]  attr_index;
    logic [31:0] attr_value;
    logic        last;
  } spd_out_t;

  // queue entry: the word plus its class
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              decode;
  } spd_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_PREP,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/ddr3_spd_decoder_top.sv]
// DDR3 SPD decoder top level: configuration register, front queue and back end.
// A plain SPD word is registered in the queue and written to the store when the
// idle back end pops it; up to 4 words queue while a decode runs. Word 127 starts
// a decode: a sweep of the store and the MTB division, then 19 results, the status
// word first, in consecutive cycles (1 when the type byte misses).
// Synchronous reset clears control state and sets type_code to 11.
module ddr3_spd_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  ddr3spd_pkg::spd_in_t              item,
  output logic                              strobe,
  output ddr3spd_pkg::spd_out_t             result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ddr3spd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [7:0]             type_code;
  logic                   reg_hit;
  ddr3spd_pkg::spd_item_t head;
  logic                   head_valid;
  logic                   pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ddr3spd_pkg::PADDR_W-1] == ddr3spd_pkg::REG_TYPE_CODE);
  assign prdata  = reg_hit ? {24'h000000, type_code} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_code <= ddr3spd_pkg::DDR3_TYPE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      type_code <= pwdata[7:0];
    end
  end

  ddr3spd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  ddr3spd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .type_code (type_code),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

[hw/rtl/ddr3spd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ddr3spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ddr3spd_front.sv]
// Front end: takes SPD words, marks the one that starts a decode, and queues them.
// Depends on ddr3spd_pkg.
module ddr3spd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  ddr3spd_pkg::spd_in_t   item,
  output logic                   busy,
  output ddr3spd_pkg::spd_item_t head,
  output logic                   head_valid,
  input  logic                   pop
);

  ddr3spd_pkg::spd_item_t q [ddr3spd_pkg::QUEUE_DEPTH];
  logic [ddr3spd_pkg::QPTR_W-1:0] wr_ptr;
  logic [ddr3spd_pkg::QPTR_W-1:0] rd_ptr;
  logic [ddr3spd_pkg::QCNT_W-1:0] count;
  logic                           push;
  ddr3spd_pkg::spd_item_t         entry;

  assign busy       = (count == ddr3spd_pkg::QCNT_W'(ddr3spd_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  always_comb begin
    entry.addr   = item.byte_address;
    entry.data   = item.spd_byte;
    entry.decode = (item.byte_address == ddr3spd_pkg::START_ADDR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ddr3spd_pkg::QCNT_W'(ddr3spd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

[hw/rtl/ddr3spd_back.sv]
// Back end: stores queued words, sweeps the store on a decode (CRC and byte
// capture), divides out the MTB and emits the attributes. Depends on
// ddr3spd_pkg and ddr3spd_ram.
module ddr3spd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             type_code,
  input  ddr3spd_pkg::spd_item_t head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   strobe,
  output ddr3spd_pkg::spd_out_t  result
);

  ddr3spd_pkg::back_state_t state;
  ddr3spd_pkg::back_state_t state_next;

  logic [ddr3spd_pkg::SWEEP_W-1:0] iss;
  logic                            issuing;
  logic [ddr3spd_pkg::ADDR_W-1:0]  ram_raddr;
  logic [7:0]                      ram_rdata;
  logic                            dv;
  logic [ddr3spd_pkg::ADDR_W-1:0]  d_addr;
  logic                            sweep_done;
  logic                            crc_take;
  logic [15:0]                     crc;

  logic [7:0] spd_copy [ddr3spd_pkg::COPY_BYTES];
  logic       mirror;
  logic [7:0] crc_lo;
  logic [7:0] crc_hi;

  logic        ddr3;
  logic        crc_ok;
  logic        mtb_zero;
  logic [31:0] size;
  logic [15:0] dq;
  logic [7:0]  rem;
  logic [8:0]  trial;
  logic        qbit;
  logic [3:0]  div_cnt;
  logic [4:0]  attr_k;

  logic [3:0]  ranks;
  logic [4:0]  shl;
  logic [3:0]  shr;
  logic [15:0] mtb;
  logic [15:0] operand;
  logic [31:0] product;
  logic [13:0] flags;
  logic [31:0] value;

  ddr3spd_ram #(
    .WIDTH(8),
    .DEPTH(ddr3spd_pkg::SPD_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (pop),
    .waddr(head.addr),
    .wdata(head.data),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ddr3spd_pkg::BK_IDLE: begin
        if (head_valid && head.decode) begin
          state_next = ddr3spd_pkg::BK_SWEEP;
        end
      end
      ddr3spd_pkg::BK_SWEEP: begin
        if (sweep_done) begin
          state_next = ddr3spd_pkg::BK_PREP;
        end
      end
      ddr3spd_pkg::BK_PREP: begin
        state_next = ddr3spd_pkg::BK_DIV;
      end
      ddr3spd_pkg::BK_DIV: begin
        if (div_cnt == 4'(ddr3spd_pkg::DIV_STEPS - 1)) begin
          state_next = ddr3spd_pkg::BK_EMIT;
        end
      end
      ddr3spd_pkg::BK_EMIT: begin
        if (!ddr3 || attr_k == ddr3spd_pkg::ATTR_TFAW) begin
          state_next = ddr3spd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ddr3spd_pkg::BK_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    pop     = 1'b0;
    issuing = 1'b0;
    case (state)
      ddr3spd_pkg::BK_IDLE: begin
        pop = head_valid;
      end
      ddr3spd_pkg::BK_SWEEP: begin
        issuing = (iss != ddr3spd_pkg::SWEEP_W'(ddr3spd_pkg::SPD_BYTES));
      end
      default: begin
        pop     = 1'b0;
        issuing = 1'b0;
      end
    endcase
  end

  assign ram_raddr  = iss[ddr3spd_pkg::ADDR_W-1:0];
  assign sweep_done = dv && (d_addr == ddr3spd_pkg::ADDR_W'(ddr3spd_pkg::SPD_BYTES - 1));
  // byte 0 always counts; its bit 7 picks the length for the rest
  assign crc_take   = dv && ((d_addr == '0) ||
                             (spd_copy[0][7] ? (d_addr < ddr3spd_pkg::CRC_SHORT_LEN)
                                             : (d_addr < ddr3spd_pkg::CRC_LONG_LEN)));

  // geometry and divider step
  always_comb begin
    ranks = {1'b0, spd_copy[7][5:3]} + 4'd1;
    shl   = 5'(spd_copy[4] & ddr3spd_pkg::LOW_NIBBLE) + 5'd4 + 5'(spd_copy[8][2:0]);
    shr   = 4'd2 + 4'(spd_copy[7][2:0]);
    trial = {rem, dq[15]};
    qbit  = (trial >= {1'b0, spd_copy[11]});
  end

  // attribute value for the current index
  always_comb begin
    mtb = mtb_zero ? 16'h0000 : dq;
    case (attr_k)
      ddr3spd_pkg::ATTR_TCK:  operand = {8'h00, spd_copy[12]};
      ddr3spd_pkg::ATTR_TAA:  operand = {8'h00, spd_copy[16]};
      ddr3spd_pkg::ATTR_TWR:  operand = {8'h00, spd_copy[17]};
      ddr3spd_pkg::ATTR_TRCD: operand = {8'h00, spd_copy[18]};
      ddr3spd_pkg::ATTR_TRRD: operand = {8'h00, spd_copy[19]};
      ddr3spd_pkg::ATTR_TRP:  operand = {8'h00, spd_copy[20]};
      ddr3spd_pkg::ATTR_TRAS: operand = {4'h0, spd_copy[21][3:0], spd_copy[22]};
      ddr3spd_pkg::ATTR_TRC:  operand = {4'h0, spd_copy[21][7:4], spd_copy[23]};
      ddr3spd_pkg::ATTR_TRFC: operand = {spd_copy[25], spd_copy[24]};
      ddr3spd_pkg::ATTR_TWTR: operand = {8'h00, spd_copy[26]};
      ddr3spd_pkg::ATTR_TRTP: operand = {8'h00, spd_copy[27]};
      ddr3spd_pkg::ATTR_TFAW: operand = {4'h0, spd_copy[28][3:0], spd_copy[29]};
      default:                operand = 16'h0000;
    endcase
    product = operand * mtb;

    flags[0]  = !spd_copy[6][0];
    flags[1]  = spd_copy[6][1];
    flags[2]  = spd_copy[6][2];
    flags[3]  = |spd_copy[8][4:3];
    flags[4]  = spd_copy[30][7];
    flags[5]  = spd_copy[30][1];
    flags[6]  = spd_copy[30][0];
    flags[7]  = spd_copy[31][7];
    flags[8]  = spd_copy[31][3];
    flags[9]  = spd_copy[31][2];
    flags[10] = spd_copy[31][0];
    flags[11] = spd_copy[31][1];
    flags[12] = spd_copy[32][7];
    flags[13] = mirror;

    case (attr_k)
      ddr3spd_pkg::ATTR_STATUS:  value = ddr3 ? {29'h0, mtb_zero, crc_ok, 1'b1} : 32'h0;
      ddr3spd_pkg::ATTR_ROWBITS: value = 32'(5'(spd_copy[5][6:4]) + 5'd12);
      ddr3spd_pkg::ATTR_COLBITS: value = 32'(5'(spd_copy[5][2:0]) + 5'd9);
      ddr3spd_pkg::ATTR_RANKS:   value = 32'(ranks);
      ddr3spd_pkg::ATTR_SIZE:    value = size;
      ddr3spd_pkg::ATTR_FLAGS:   value = 32'(flags);
      ddr3spd_pkg::ATTR_CAS:     value = {16'h0000, spd_copy[15], spd_copy[14]};
      default:                   value = product;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ddr3spd_pkg::BK_IDLE;
      dv     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      dv     <= issuing;
      strobe <= (state == ddr3spd_pkg::BK_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    d_addr <= ram_raddr;
    if (pop) begin
      iss <= '0;
      crc <= 16'h0000;
    end
    if (issuing) begin
      iss <= iss + 1'b1;
    end
    if (dv) begin
      if (d_addr < ddr3spd_pkg::ADDR_W'(ddr3spd_pkg::COPY_BYTES)) begin
        spd_copy[d_addr[ddr3spd_pkg::COPY_W-1:0]] <= ram_rdata;
      end
      if (d_addr == ddr3spd_pkg::MIRROR_BYTE) begin
        mirror <= ram_rdata[0];
      end
      if (d_addr == ddr3spd_pkg::CRC_LO_BYTE) begin
        crc_lo <= ram_rdata;
      end
      if (d_addr == ddr3spd_pkg::CRC_HI_BYTE) begin
        crc_hi <= ram_rdata;
      end
    end
    if (crc_take) begin
      crc <= ddr3spd_pkg::crc16_byte(crc, ram_rdata);
    end
    if (state == ddr3spd_pkg::BK_PREP) begin
      ddr3     <= (spd_copy[2] == type_code);
      crc_ok   <= (crc == {crc_hi, crc_lo});
      mtb_zero <= (spd_copy[11] == 8'h00);
      size     <= ((32'(ranks) << shl) >> shr);
      dq       <= {spd_copy[10], 8'h00};
      rem      <= 8'h00;
      div_cnt  <= '0;
      attr_k   <= ddr3spd_pkg::ATTR_STATUS;
    end
    if (state == ddr3spd_pkg::BK_DIV) begin
      // restoring division, one quotient bit a cycle
      rem     <= qbit ? 8'(trial - {1'b0, spd_copy[11]}) : trial[7:0];
      dq      <= {dq[14:0], qbit};
      div_cnt <= div_cnt + 1'b1;
    end
    if (state == ddr3spd_pkg::BK_EMIT) begin
      result.attr_index <= attr_k;
      result.attr_value <= value;
      result.last       <= !ddr3 || (attr_k == ddr3spd_pkg::ATTR_TFAW);
      attr_k            <= attr_k + 1'b1;
    end
  end

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe && result.attr_index == $past(result.attr_index) + 5'd1)
    else $error("attribute sequence broken");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("word after last attribute");

  a_first_status: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> result.attr_index == ddr3spd_pkg::ATTR_STATUS)
    else $error("decode did not open with status");

endmodule
